/* sv/sljcf_pkg.sv */
// ----------------------------------------------------------------------------
// sljcf_pkg
// shared types, codes and constants of the sync/length/crc16 frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package sljcf_pkg;

	localparam logic [7:0]  SYNC_FIRST      = 8'h55;
	localparam logic [7:0]  SYNC_SECOND     = 8'hAA;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd200;
	localparam logic [15:0] TIMER_MAX       = 16'hFFFF;
	localparam logic [15:0] MIN_LENGTH      = 16'd2;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SYNC1   = 3'd1,
		PH_SYNC2   = 3'd2,
		PH_LENHI   = 3'd3,
		PH_LENLO   = 3'd4,
		PH_CHKHI   = 3'd5,
		PH_DATA    = 3'd6,
		PH_TRAILER = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		RK_PAYLOAD = 3'd0,
		RK_GOOD    = 3'd1,
		RK_BADCRC  = 3'd2,
		RK_TIMEOUT = 3'd3,
		RK_REJECT  = 3'd4
	} result_kind_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic [15:0] command_id;
	} result_t;

	// one byte through the reflected crc-16, bit at a time
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* sv/sljcf_if.sv */
// ----------------------------------------------------------------------------
// sljcf_if
// valid/ready channels for receive items and for results
// ----------------------------------------------------------------------------
`default_nettype none

interface sljcf_rx_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sljcf_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic [15:0] command_id;

	modport source (output valid, output result_kind, output payload_byte,
		output byte_index, output command_id, input ready);
	modport sink   (input valid, input result_kind, input payload_byte,
		input byte_index, input command_id, output ready);
endinterface

`default_nettype wire

/* sv/sljcf_crc.sv */
// ----------------------------------------------------------------------------
// sljcf_crc
// one-byte crc-16/modbus update
// ----------------------------------------------------------------------------
`default_nettype none

module sljcf_crc (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);
	import sljcf_pkg::*;

	assign crc_out = crc16_byte(crc_in, data);

endmodule

`default_nettype wire

/* sv/sljcf_core.sv */
// ----------------------------------------------------------------------------
// sljcf_core
// frame state machine: sync hunt, length check, payload stream, verdict
// ----------------------------------------------------------------------------
`default_nettype none

module sljcf_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire sljcf_pkg::item_t  item,
	input  wire logic [15:0]       timeout_ticks,
	output logic                   res_valid,
	output sljcf_pkg::result_t     res
);
	import sljcf_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] frame_length_q, frame_length_d;
	logic [7:0]  check_high_q, check_high_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] held_q, held_d;
	logic [15:0] command_q, command_d;
	logic [15:0] timer_q, timer_d;

	logic [15:0] crc_upd;
	logic [15:0] tick_count;
	logic [15:0] comp;
	logic [15:0] idx;
	logic        timed_out;

	sljcf_crc u_crc (
		.crc_in  (crc_q),
		.data    (held_q[15:8]),
		.crc_out (crc_upd)
	);

	assign tick_count = (timer_q != TIMER_MAX) ? timer_q + 16'd1 : timer_q;
	assign timed_out  = (phase_q != PH_HUNT) && (tick_count >= timeout_ticks);
	assign comp       = ~{check_high_q, item.rx_byte};
	assign idx        = frame_length_q - bytes_left_q;

	// next state
	always_comb begin
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		check_high_d   = check_high_q;
		bytes_left_d   = bytes_left_q;
		crc_d          = crc_q;
		held_d         = held_q;
		command_d      = command_q;
		timer_d        = timer_q;
		if (item.kind == KIND_TICK) begin
			if (phase_q != PH_HUNT) begin
				timer_d = tick_count;
				if (timed_out) begin
					phase_d = PH_HUNT;
				end
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (item.rx_byte == SYNC_FIRST) begin
						phase_d = PH_SYNC1;
						timer_d = '0;
					end
				end
				PH_SYNC1: begin
					phase_d = (item.rx_byte == SYNC_SECOND) ? PH_SYNC2 : PH_HUNT;
				end
				PH_SYNC2: begin
					frame_length_d = {item.rx_byte, 8'h00};
					phase_d        = PH_LENHI;
				end
				PH_LENHI: begin
					frame_length_d = {frame_length_q[15:8], item.rx_byte};
					phase_d        = PH_LENLO;
				end
				PH_LENLO: begin
					check_high_d = item.rx_byte;
					phase_d      = PH_CHKHI;
				end
				PH_CHKHI: begin
					if (comp != frame_length_q || frame_length_q < MIN_LENGTH) begin
						phase_d = PH_HUNT;
					end else begin
						bytes_left_d = frame_length_q;
						crc_d        = CRC_INIT;
						held_d       = '0;
						command_d    = '0;
						phase_d      = PH_DATA;
					end
				end
				PH_DATA: begin
					if (idx >= 16'd2) begin
						crc_d = crc_upd;
					end
					held_d = {held_q[7:0], item.rx_byte};
					if (idx == 16'd0) begin
						command_d = {item.rx_byte, 8'h00};
					end else if (idx == 16'd1) begin
						command_d = {command_q[15:8], item.rx_byte};
					end
					bytes_left_d = bytes_left_q - 16'd1;
					if (bytes_left_q == 16'd1) begin
						phase_d = PH_TRAILER;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (item.kind == KIND_TICK) begin
			if (timed_out) begin
				res_valid       = 1'b1;
				res.result_kind = RK_TIMEOUT;
			end
		end else begin
			case (phase_q)
				PH_CHKHI: begin
					if (comp == frame_length_q && frame_length_q < MIN_LENGTH) begin
						res_valid       = 1'b1;
						res.result_kind = RK_REJECT;
					end
				end
				PH_DATA: begin
					res_valid        = 1'b1;
					res.result_kind  = RK_PAYLOAD;
					res.payload_byte = item.rx_byte;
					res.byte_index   = idx;
				end
				PH_TRAILER: begin
					res_valid = 1'b1;
					if (crc_q == held_q) begin
						res.result_kind = RK_GOOD;
						res.command_id  = command_q;
					end else begin
						res.result_kind = RK_BADCRC;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			frame_length_q <= '0;
			check_high_q   <= '0;
			bytes_left_q   <= '0;
			crc_q          <= CRC_INIT;
			held_q         <= '0;
			command_q      <= '0;
			timer_q        <= '0;
		end else if (go) begin
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			check_high_q   <= check_high_d;
			bytes_left_q   <= bytes_left_d;
			crc_q          <= crc_d;
			held_q         <= held_d;
			command_q      <= command_d;
			timer_q        <= timer_d;
		end
	end

endmodule

`default_nettype wire

/* sv/sync_length_crc16_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// serial frame receiver with sync, checked length and crc-16/modbus trailer
// ----------------------------------------------------------------------------
// Takes one beat per clock: a received byte or a timer tick. Frames are
// 0x55 0xAA, length (big-endian), its complement, then the payload whose last
// two bytes are a big-endian crc-16/modbus over the rest. Each payload byte
// comes out as its own result beat with its index; one byte after the payload
// yields the verdict (good with command id, or crc bad). Ticks abort an open
// frame after timeout_ticks, lengths below two are rejected. Sustained rate is
// one item per clock unless the result channel pushes back. An item is held
// in the input register, then the core's state update and the output register
// load of its result beat happen together when it moves on. Backpressure on
// the result channel stalls the input register and, through it, rx.ready.
`default_nettype none

module sync_length_crc16_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	sljcf_rx_if.sink         rx,
	sljcf_res_if.source      result
);
	import sljcf_pkg::*;

	// timeout register
	logic [15:0] timeout_q;

	// input register stage
	logic        valid_s1;
	item_t       item_s1;

	// output register
	logic        out_valid_q;
	result_t     out_q;

	// core interface
	logic        advance;
	logic        core_valid;
	result_t     core_res;

	// the item in s1 moves on when the output register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || result.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1.kind    <= rx.kind;
			item_s1.rx_byte <= rx.rx_byte;
		end
	end

	sljcf_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (advance),
		.item          (item_s1),
		.timeout_ticks (timeout_q),
		.res_valid     (core_valid),
		.res           (core_res)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= core_valid;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			out_q <= core_res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_kind  = out_q.result_kind;
	assign result.payload_byte = out_q.payload_byte;
	assign result.byte_index   = out_q.byte_index;
	assign result.command_id   = out_q.command_id;

	// a produced result always lands in the output register
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && core_valid |=> result.valid)
		else $error("core result not registered");

	// input is only held off while a beat waits in s1 behind a pending result
	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && out_valid_q && !result.ready)
		else $error("input stalled without cause");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !advance)
		else $error("pending result overwritten");

endmodule

`default_nettype wire
